>>> hdl/pdct_pkg.sv
`timescale 1ns / 1ps

package pdct_pkg;

  localparam int ENTRIES   = 32;
  localparam int TIME_BITS = 40;

  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int ADDR_W = 48;
  localparam int NOW_W  = 40;
  localparam int SLOT_W = 5;
  localparam int CFG_W  = 32;
  localparam int CMP_W  = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;

  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_DEDUP    = CFG_IDX_W'(1);

  localparam logic [CFG_W-1:0] COOLDOWN_RESET = CFG_W'(1800000);
  localparam logic [CFG_W-1:0] DEDUP_RESET    = CFG_W'(2000);

  typedef struct packed {
    logic [ADDR_W-1:0] peer_address;
    logic [NOW_W-1:0]  now_ms;
    logic              gates_open;
  } in_t;

  typedef struct packed {
    logic              connect;
    logic [SLOT_W-1:0] slot;
    logic              was_new;
    logic              evicted;
  } out_t;

  typedef struct packed {
    logic [ADDR_W-1:0]    addr;
    logic [TIME_BITS-1:0] seen;
    logic [TIME_BITS-1:0] conn;
  } ent_t;

endpackage

>>> hdl/peer_dedup_cooldown_table_unit.sv
// peer sighting table with connect cooldown and dedup window
//
// input channel (in_valid_i / in_stall_o, payload in_data_i) carries one
// sighting: peer address, current ms time and a gate bit. each sighting gives
// exactly one result on the output channel (out_valid_o / out_stall_i,
// payload out_data_o): connect grant, table slot, new flag, eviction flag.
// cooldown and dedup spans are written on the cfg port (always ready); the
// user must write them only while the block is idle, which the block itself
// does not enforce. a sighting takes one pass over the stored entries through
// the single table read port, then, when a miss hits a full table, a search
// over all ENTRIES for the oldest entry, then the two window checks (one
// shared subtractor) and the table write. one sighting is in flight at a
// time; in_stall_o is high until its result is loaded.
// the result sits in an output register, so a new sighting is taken while
// the receiver stalls; a finished result waits for the register to free.
// reset empties the table (entry count zero) and restores the default spans.
`timescale 1ns / 1ps

module peer_dedup_cooldown_table_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  pdct_pkg::in_t                       in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output pdct_pkg::out_t                      out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [pdct_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [pdct_pkg::CFG_W-1:0]          cfg_data_i
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_EVICT = 3'd2;
  localparam logic [2:0] S_CHK0  = 3'd3;
  localparam logic [2:0] S_CHK1  = 3'd4;
  localparam logic [2:0] S_WR    = 3'd5;

  localparam logic [pdct_pkg::CNT_W-1:0] FULL = pdct_pkg::CNT_W'(pdct_pkg::ENTRIES);

  logic [2:0] state_q, state_d;
  logic [pdct_pkg::CNT_W-1:0] count_q, count_d;
  logic [pdct_pkg::CNT_W-1:0] idx_q, idx_d;
  logic                       rvalid_q, rvalid_d;
  logic [pdct_pkg::IDX_W-1:0] cmp_idx_q, cmp_idx_d;
  logic [pdct_pkg::IDX_W-1:0] slot_q, slot_d;
  logic [pdct_pkg::TIME_BITS-1:0] min_q, min_d;
  logic [pdct_pkg::TIME_BITS-1:0] seen_q, seen_d;
  logic [pdct_pkg::TIME_BITS-1:0] conn_q, conn_d;
  logic was_new_q, was_new_d;
  logic evicted_q, evicted_d;
  logic open_c_q, open_c_d;
  logic open_s_q, open_s_d;
  pdct_pkg::in_t item_q, item_d;
  logic [pdct_pkg::CFG_W-1:0] cooldown_q, dedup_q;
  logic       out_valid_q, out_valid_d;
  pdct_pkg::out_t out_q, out_d;

  pdct_pkg::ent_t entry_mem_q [pdct_pkg::ENTRIES];
  pdct_pkg::ent_t rdata_q;
  logic [pdct_pkg::IDX_W-1:0] raddr;
  logic           we;
  pdct_pkg::ent_t wdata;

  logic [pdct_pkg::TIME_BITS-1:0] now;
  logic [pdct_pkg::TIME_BITS-1:0] since;
  logic [pdct_pkg::CFG_W-1:0]     span;
  logic [pdct_pkg::TIME_BITS:0]   diff;
  logic                           win_open;
  logic                           issue;
  logic                           grant;

  assign now = pdct_pkg::TIME_BITS'(item_q.now_ms);

  // shared window unit: since != 0 and (now < since or now - since < span)
  always_comb begin
    if (state_q == S_CHK0) begin
      since = conn_q;
      span  = cooldown_q;
    end else begin
      since = seen_q;
      span  = dedup_q;
    end
    diff = {1'b0, now} - {1'b0, since};
    win_open = (since != '0) &&
               (diff[pdct_pkg::TIME_BITS] ||
                (pdct_pkg::CMP_W'(diff[pdct_pkg::TIME_BITS-1:0]) <
                 pdct_pkg::CMP_W'(span)));
  end

  assign grant = item_q.gates_open && !open_c_q && !open_s_q;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    rvalid_d    = 1'b0;
    cmp_idx_d   = cmp_idx_q;
    slot_d      = slot_q;
    min_d       = min_q;
    seen_d      = seen_q;
    conn_d      = conn_q;
    was_new_d   = was_new_q;
    evicted_d   = evicted_q;
    open_c_d    = open_c_q;
    open_s_d    = open_s_q;
    item_d      = item_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    raddr       = idx_q[pdct_pkg::IDX_W-1:0];
    issue       = 1'b0;
    we          = 1'b0;
    wdata       = '{addr: item_q.peer_address, seen: seen_q, conn: conn_q};

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          item_d  = in_data_i;
          idx_d   = '0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        issue = idx_q < count_q;
        if (issue) begin
          idx_d     = idx_q + 1'b1;
          rvalid_d  = 1'b1;
          cmp_idx_d = idx_q[pdct_pkg::IDX_W-1:0];
        end
        if (rvalid_q && rdata_q.addr == item_q.peer_address) begin
          slot_d    = cmp_idx_q;
          seen_d    = rdata_q.seen;
          conn_d    = rdata_q.conn;
          was_new_d = 1'b0;
          evicted_d = 1'b0;
          state_d   = S_CHK0;
        end else if (!issue) begin
          // miss: append while there is room, else search for the oldest
          was_new_d = 1'b1;
          seen_d    = '0;
          conn_d    = '0;
          if (count_q != FULL) begin
            slot_d    = pdct_pkg::IDX_W'(count_q);
            count_d   = count_q + 1'b1;
            evicted_d = 1'b0;
            state_d   = S_CHK0;
          end else begin
            evicted_d = 1'b1;
            idx_d     = '0;
            rvalid_d  = 1'b0;
            state_d   = S_EVICT;
          end
        end
      end
      S_EVICT: begin
        issue = idx_q != FULL;
        if (issue) begin
          idx_d     = idx_q + 1'b1;
          rvalid_d  = 1'b1;
          cmp_idx_d = idx_q[pdct_pkg::IDX_W-1:0];
        end
        // strict less-than keeps the lowest index on a tie
        if (rvalid_q && (cmp_idx_q == '0 || rdata_q.seen < min_q)) begin
          min_d  = rdata_q.seen;
          slot_d = cmp_idx_q;
        end
        if (!issue && rvalid_q) begin
          state_d = S_CHK0;
        end
      end
      S_CHK0: begin
        open_c_d = win_open;
        state_d  = S_CHK1;
      end
      S_CHK1: begin
        open_s_d = win_open;
        state_d  = S_WR;
      end
      S_WR: begin
        if (!out_valid_q || !out_stall_i) begin
          we = 1'b1;
          if (grant) begin
            wdata.seen = now;
            wdata.conn = now;
          end
          out_valid_d     = 1'b1;
          out_d.connect   = grant;
          out_d.slot      = pdct_pkg::SLOT_W'(slot_q);
          out_d.was_new   = was_new_q;
          out_d.evicted   = evicted_q;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      rvalid_q    <= 1'b0;
      out_valid_q <= 1'b0;
      cooldown_q  <= pdct_pkg::COOLDOWN_RESET;
      dedup_q     <= pdct_pkg::DEDUP_RESET;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rvalid_q    <= rvalid_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        if (cfg_index_i == pdct_pkg::REG_COOLDOWN) begin
          cooldown_q <= cfg_data_i;
        end else if (cfg_index_i == pdct_pkg::REG_DEDUP) begin
          dedup_q <= cfg_data_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    cmp_idx_q <= cmp_idx_d;
    slot_q    <= slot_d;
    min_q     <= min_d;
    seen_q    <= seen_d;
    conn_q    <= conn_d;
    was_new_q <= was_new_d;
    evicted_q <= evicted_d;
    open_c_q  <= open_c_d;
    open_s_q  <= open_s_d;
    item_q    <= item_d;
    out_q     <= out_d;
  end

  // entry table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we) begin
      entry_mem_q[slot_q] <= wdata;
    end
    rdata_q <= entry_mem_q[raddr];
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

endmodule

>>> hdl/pdct_checker.sv
`timescale 1ns / 1ps

module pdct_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input pdct_pkg::out_t                 out_data_o
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // an accepted sighting keeps the block busy in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("not busy after sighting transfer");

  // a result only appears out of a busy block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without pending sighting");

  // eviction only happens for a new address
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.evicted |-> out_data_o.was_new)
    else $error("eviction on a table hit");

endmodule

bind peer_dedup_cooldown_table_unit pdct_checker u_pdct_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
